FILE: rtl/paz_pkg.sv
// Shared types, widths and constants for the planar azimuth block.
// The CORDIC step-angle table is built here at elaboration.
// Depends on nothing; every rtl module imports it.
package paz_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int AZ_W        = FRAC_BITS + 9;

  localparam int DIFF_W      = COORD_WIDTH + 1;  // coordinate difference
  localparam int NORM_W      = 60;               // normalized top bit sits at 59
  localparam int NORM_STAGES = 6;                // shifts of 32, 16, 8, 4, 2, 1
  localparam int SHIFT_W     = NORM_STAGES;
  localparam int NORM_MAX    = 1 << (NORM_STAGES - 1);

  localparam int CW          = 64;               // CORDIC x/y datapath
  localparam int ANG_FRAC    = 52;
  localparam int ANG_W       = ANG_FRAC + 1;     // angle in 45-degree units, 0..1
  localparam int Z_W         = ANG_FRAC + 4;     // signed running angle
  localparam int STEPS       = 52;
  localparam int STEP_W      = $clog2(STEPS);
  localparam int SER_FRAC    = 62;

  localparam int PHI_W       = ANG_W + 1;        // 0..2 units
  localparam int A_W         = ANG_FRAC + 4;     // 0..8 units
  localparam int PROD_W      = A_W + 6;          // times 45
  localparam int RND_SHIFT   = ANG_FRAC - FRAC_BITS;

  localparam logic [ANG_W-1:0]  UNIT      = ANG_W'(1) << ANG_FRAC;
  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (RND_SHIFT - 1);
  localparam logic [AZ_W-1:0]   FULL_TURN = AZ_W'(360) << FRAC_BITS;

  typedef logic [ANG_W-1:0] ang_t;
  typedef ang_t [STEPS-1:0] ang_tab_t;

  typedef struct packed {
    logic zero;
    logic swap;
    logic dx_neg;
    logic dy_neg;
  } side_t;

  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [NORM_W-1:0] big;
    logic [NORM_W-1:0] small_c;
  } norm_t;

  typedef struct packed {
    logic                 valid;
    side_t                side;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [Z_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic            valid;
    logic [AZ_W-1:0] az;
  } res_t;

  // Bitwise long division, elaboration only.
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], num[k]};
      if (r >= den) begin
        r = r - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in radians, SER_FRAC fractional bits, power series
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] term;
    p = udiv(64'd1 << SER_FRAC, n);
    s = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        term = udiv(p, 64'(2 * k + 1));
        if ((k & 1) == 0) s = s + term;
        else s = s - term;
        p = udiv(udiv(p, n), n);
      end
    end
    return s;
  endfunction

  // atan(2^-i) as a fraction of 45 degrees, ANG_FRAC bits, truncated
  function automatic ang_tab_t build_step_table();
    logic [63:0] qp;
    logic [63:0] rem;
    logic [63:0] q;
    ang_tab_t    t;
    qp = 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
    t = '0;
    t[0] = UNIT;
    for (int i = 1; i < STEPS; i++) begin
      rem = atan_recip(64'd1 << i);
      q = '0;
      for (int b = 0; b < ANG_FRAC; b++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= qp) begin
          rem = rem - qp;
          q[0] = 1'b1;
        end
      end
      t[i] = q[ANG_W-1:0];
    end
    return t;
  endfunction

  localparam ang_tab_t STEP_ANGLE = build_step_table();

endpackage

FILE: rtl/paz_front.sv
// Front end: coordinate differences, magnitudes and octant fold.
// Three register stages, all advanced by one enable.
// Depends on paz_pkg.
module paz_front
  import paz_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  output norm_t                         d_out
);

  logic                     v1;
  logic signed [DIFF_W-1:0] dx1;
  logic signed [DIFF_W-1:0] dy1;
  logic                     v2;
  logic [DIFF_W-1:0]        ax2;
  logic [DIFF_W-1:0]        ay2;
  logic                     dx_neg2;
  logic                     dy_neg2;
  logic                     swap_next;

  assign swap_next = (ay2 > ax2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      d_out.valid <= 1'b0;
    end else if (en) begin
      v1          <= in_valid;
      v2          <= v1;
      d_out.valid <= v2;
    end
    if (en) begin
      dx1 <= $signed({first_x[COORD_WIDTH-1], first_x})
           - $signed({second_x[COORD_WIDTH-1], second_x});
      dy1 <= $signed({first_y[COORD_WIDTH-1], first_y})
           - $signed({second_y[COORD_WIDTH-1], second_y});

      dx_neg2 <= dx1[DIFF_W-1];
      dy_neg2 <= dy1[DIFF_W-1];
      ax2     <= dx1[DIFF_W-1] ? DIFF_W'(-dx1) : DIFF_W'(dx1);
      ay2     <= dy1[DIFF_W-1] ? DIFF_W'(-dy1) : DIFF_W'(dy1);

      d_out.side.zero   <= (ax2 == '0) && (ay2 == '0);
      d_out.side.swap   <= swap_next;
      d_out.side.dx_neg <= dx_neg2;
      d_out.side.dy_neg <= dy_neg2;
      d_out.big         <= NORM_W'(swap_next ? ay2 : ax2);
      d_out.small_c     <= NORM_W'(swap_next ? ax2 : ay2);
    end
  end

endmodule

FILE: rtl/paz_norm_cell.sv
// One normalization cell: shifts the vector left by a fixed amount when
// the top bits of the larger component are clear.
// Depends on paz_pkg.
module paz_norm_cell
  import paz_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [SHIFT_W-1:0] amt,
  input  norm_t              d_in,
  output norm_t              d_out
);

  logic [NORM_W-1:0] top_mask;
  logic              do_shift;

  assign top_mask = ~({NORM_W{1'b1}} >> amt);
  assign do_shift = (d_in.big & top_mask) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_in.valid;
    end
    if (en) begin
      d_out.side    <= d_in.side;
      d_out.big     <= do_shift ? (d_in.big << amt) : d_in.big;
      d_out.small_c <= do_shift ? (d_in.small_c << amt) : d_in.small_c;
    end
  end

endmodule

FILE: rtl/paz_cordic_cell.sv
// One CORDIC vectoring micro-rotation; the step index picks shift and angle.
// Shifts of negative values floor (arithmetic shift).
// Depends on paz_pkg.
module paz_cordic_cell
  import paz_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  cordic_t           d_in,
  output cordic_t           d_out
);

  logic signed [CW-1:0]  xs;
  logic signed [CW-1:0]  ys;
  logic signed [Z_W-1:0] ang;
  logic signed [CW-1:0]  x_next;
  logic signed [CW-1:0]  y_next;
  logic signed [Z_W-1:0] z_next;

  always_comb begin
    xs  = d_in.x >>> step;
    ys  = d_in.y >>> step;
    ang = $signed(Z_W'(STEP_ANGLE[step]));
    if (!d_in.y[CW-1]) begin
      x_next = d_in.x + ys;
      y_next = d_in.y - xs;
      z_next = d_in.z + ang;
    end else begin
      x_next = d_in.x - ys;
      y_next = d_in.y + xs;
      z_next = d_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_in.valid;
    end
    if (en) begin
      d_out.side <= d_in.side;
      d_out.x    <= x_next;
      d_out.y    <= y_next;
      d_out.z    <= z_next;
    end
  end

endmodule

FILE: rtl/paz_back.sv
// Back end: octant unfold to a full-circle angle, scale to degrees, round.
// Three register stages; the 360 wrap is left to the output stage.
// Depends on paz_pkg.
module paz_back
  import paz_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cordic_t d_in,
  output res_t    d_out
);

  localparam logic signed [Z_W-1:0] UNIT_Z  = $signed(Z_W'(UNIT));
  localparam logic signed [A_W:0]   UNIT_A  = $signed((A_W + 1)'(UNIT));
  localparam logic signed [A_W:0]   EIGHT_A = UNIT_A <<< 3;

  logic [ANG_W-1:0]  zc;
  logic              v1;
  side_t             side1;
  logic [PHI_W-1:0]  phi1;
  logic signed [A_W:0] phi_s;
  logic signed [A_W:0] a_s;
  logic [A_W-1:0]    a_next;
  logic              v2;
  logic              zero2;
  logic [A_W-1:0]    a2;
  logic [PROD_W-1:0] a_w;
  logic [PROD_W-1:0] prod;

  always_comb begin
    if (d_in.z[Z_W-1]) zc = '0;
    else if (d_in.z > UNIT_Z) zc = UNIT;
    else zc = d_in.z[ANG_W-1:0];
  end

  always_comb begin
    phi_s = $signed((A_W + 1)'(phi1));
    if (!side1.dx_neg && !side1.dy_neg) a_s = phi_s;
    else if (side1.dx_neg && !side1.dy_neg) a_s = (UNIT_A <<< 2) - phi_s;
    else if (side1.dx_neg) a_s = (UNIT_A <<< 2) + phi_s;
    else a_s = EIGHT_A - phi_s;
    if (a_s[A_W]) a_next = '0;
    else if (a_s > EIGHT_A) a_next = EIGHT_A[A_W-1:0];
    else a_next = a_s[A_W-1:0];
  end

  // times 45 = 32 + 8 + 4 + 1
  assign a_w  = PROD_W'(a2);
  assign prod = (a_w << 5) + (a_w << 3) + (a_w << 2) + a_w + ROUND_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      d_out.valid <= 1'b0;
    end else if (en) begin
      v1          <= d_in.valid;
      v2          <= v1;
      d_out.valid <= v2;
    end
    if (en) begin
      side1 <= d_in.side;
      phi1  <= d_in.side.swap ? (PHI_W'(UNIT) << 1) - PHI_W'(zc) : PHI_W'(zc);

      zero2 <= side1.zero;
      a2    <= a_next;

      d_out.az <= zero2 ? '0 : prod[RND_SHIFT +: AZ_W];
    end
  end

endmodule

FILE: rtl/planar_azimuth_degrees.sv
// Top level: azimuth in degrees of the vector from the second point to the first.
// Front end, normalization cells, CORDIC cell chain, back end, output buffer.
// Depends on paz_pkg, paz_front, paz_norm_cell, paz_cordic_cell, paz_back.
//
//   channel  signals                                     direction  transfer when
//   in       in_valid, in_ready, first_x, first_y,      sink       in_valid && in_ready
//            second_x, second_y
//   out      out_valid, out_ready, azimuth              source     out_valid && out_ready
//
// The pipeline is 3 front stages, 6 normalization cells, 52 CORDIC cells,
// 3 back-end stages and the output register. One transfer per cycle is sustained
// while the skid register is empty: the whole pipeline moves on one enable taken
// from it, so a stalled output still lets items enter until a result fills the skid.
// rst is synchronous and clears only valid bits.
module planar_azimuth_degrees
  import paz_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [AZ_W-1:0]               azimuth
);

  logic            adv;
  logic            push;
  logic            skid_valid;
  logic [AZ_W-1:0] skid_az;
  logic [AZ_W-1:0] wrapped;
  norm_t           norm_chain [NORM_STAGES+1];
  cordic_t         cordic_chain [STEPS+1];
  res_t            res;

  assign adv      = !skid_valid;
  assign in_ready = adv;

  paz_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (in_valid),
    .first_x  (first_x),
    .first_y  (first_y),
    .second_x (second_x),
    .second_y (second_y),
    .d_out    (norm_chain[0])
  );

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam logic [SHIFT_W-1:0] AMT = SHIFT_W'(NORM_MAX >> k);
    paz_norm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .amt   (AMT),
      .d_in  (norm_chain[k]),
      .d_out (norm_chain[k+1])
    );
  end

  always_comb begin
    cordic_chain[0].valid = norm_chain[NORM_STAGES].valid;
    cordic_chain[0].side  = norm_chain[NORM_STAGES].side;
    cordic_chain[0].x     = $signed(CW'(norm_chain[NORM_STAGES].big));
    cordic_chain[0].y     = $signed(CW'(norm_chain[NORM_STAGES].small_c));
    cordic_chain[0].z     = '0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    localparam logic [STEP_W-1:0] STEP = STEP_W'(i);
    paz_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .step  (STEP),
      .d_in  (cordic_chain[i]),
      .d_out (cordic_chain[i+1])
    );
  end

  paz_back u_back (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .d_in  (cordic_chain[STEPS]),
    .d_out (res)
  );

  // a rounded full turn wraps to zero
  assign wrapped = (res.az >= FULL_TURN) ? res.az - FULL_TURN : res.az;
  assign push    = adv && res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) azimuth <= skid_az;
      else if (push) azimuth <= wrapped;
    end else if (push) begin
      skid_az <= wrapped;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_az_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (azimuth < FULL_TURN))
    else $error("azimuth not wrapped below a full turn");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !skid_valid && res.valid |=> skid_valid)
    else $error("result leaving the pipeline under stall was not caught in skid");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && skid_valid |=> out_valid && !skid_valid)
    else $error("skid result not moved to the output register");

endmodule

FILE: tb/paz_azimuth_checker.sv
// Checker for planar_azimuth_degrees: watches both channels, predicts the azimuth of each
// input transfer and compares it with the output transfers in order.
// Depends on paz_pkg for port widths and FRAC_BITS; the prediction is computed here.
module paz_azimuth_checker
  import paz_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [AZ_W-1:0]               azimuth,
  output int                            mismatches,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SERIES_FRAC  = 62;   // radians
  localparam int     TURN_FRAC    = 52;   // 45-degree units
  localparam int     CORDIC_STEPS = 52;
  localparam longint TURN_UNIT    = 64'sd1 << TURN_FRAC;
  localparam longint unsigned ROUND_HALF = 64'd1 << (TURN_FRAC - 1 - FRAC_BITS);
  localparam longint unsigned FULL_CIRCLE = 64'd360 << FRAC_BITS;

  typedef struct {
    logic [AZ_W-1:0] az;
    int unsigned     seq;
  } azimuth_due_t;

  longint unsigned step_turn [CORDIC_STEPS];
  azimuth_due_t    azimuth_due [$];
  azimuth_due_t    oldest;
  int unsigned     pairs_seen = 0;
  int              fail_count = 0;

  // atan(1/n), Gregory series in fixed point
  function automatic longint unsigned atan_inv(input longint unsigned n);
    longint unsigned p, s, term, k;
    p = (64'd1 << SERIES_FRAC) / n;
    s = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (k[0] == 1'b0) s += term;
      else s -= term;
      p = p / n / n;
      k++;
    end
    return s;
  endfunction

  initial begin : build_steps
    longint unsigned quarter_pi, rem, q;
    quarter_pi = 4 * atan_inv(5) - atan_inv(239);
    step_turn[0] = 64'd1 << TURN_FRAC;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      rem = atan_inv(64'd1 << i);
      q = 0;
      for (int b = 0; b < TURN_FRAC; b++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= quarter_pi) begin
          rem -= quarter_pi;
          q |= 64'd1;
        end
      end
      step_turn[i] = q;
    end
  end

  // first-octant angle of (major, minor), minor <= major, major > 0
  function automatic longint octant_turn(input longint unsigned major,
                                         input longint unsigned minor);
    longint x, y, z, xs, ys;
    while (major < (64'd1 << 59)) begin
      major <<= 1;
      minor <<= 1;
    end
    x = longint'(major);
    y = longint'(minor);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += longint'(step_turn[i]);
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(step_turn[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > TURN_UNIT) z = TURN_UNIT;
    return z;
  endfunction

  function automatic logic [AZ_W-1:0] predict_azimuth(
    input logic signed [COORD_WIDTH-1:0] fx,
    input logic signed [COORD_WIDTH-1:0] fy,
    input logic signed [COORD_WIDTH-1:0] sx,
    input logic signed [COORD_WIDTH-1:0] sy
  );
    longint dx, dy, phi, a;
    longint unsigned ax, ay, az;
    dx = longint'(fx) - longint'(sx);
    dy = longint'(fy) - longint'(sy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax == 0 && ay == 0) return '0;
    if (ay <= ax) phi = octant_turn(ax, ay);
    else phi = 2 * TURN_UNIT - octant_turn(ay, ax);
    if (dx >= 0 && dy >= 0) a = phi;
    else if (dx < 0 && dy >= 0) a = 4 * TURN_UNIT - phi;
    else if (dx < 0) a = 4 * TURN_UNIT + phi;
    else a = 8 * TURN_UNIT - phi;
    if (a < 0) a = 0;
    if (a > 8 * TURN_UNIT) a = 8 * TURN_UNIT;
    az = a;
    az = (az * 45 + ROUND_HALF) >> (TURN_FRAC - FRAC_BITS);
    if (az >= FULL_CIRCLE) az -= FULL_CIRCLE;
    return az[AZ_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (azimuth_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: output transfer azimuth=%0d with nothing outstanding", $time, azimuth);
          fail_count++;
        end else begin
          oldest = azimuth_due.pop_front();
          if (azimuth !== oldest.az) begin
            if (fail_count < 10)
              $display("%0t: pair %0d azimuth expected %0d got %0d",
                       $time, oldest.seq, oldest.az, azimuth);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        azimuth_due.push_back('{predict_azimuth(first_x, first_y, second_x, second_y),
                                pairs_seen});
        pairs_seen++;
      end
    end
    mismatches <= fail_count;
    pending    <= azimuth_due.size();
  end

endmodule

FILE: tb/planar_azimuth_degrees_test.sv
// Top of the planar_azimuth_degrees testbench: clock, reset, point-pair stimulus and
// output back-pressure; the verdict comes from the failure count of paz_azimuth_checker.
// Depends on paz_pkg, planar_azimuth_degrees and paz_azimuth_checker.
module planar_azimuth_degrees_test
  import paz_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t C_MAX        = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t C_MIN        = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam int     PHASE_PAIRS  = 284;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 80;   // pipeline is 65 deep

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  coord_t          first_x;
  coord_t          first_y;
  coord_t          second_x;
  coord_t          second_y;
  logic            out_valid;
  logic            out_ready;
  logic [AZ_W-1:0] azimuth;
  int              mismatches;
  int              pending;

  int send_idle;
  int recv_idle;
  bit hold_req;

  planar_azimuth_degrees dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .out_valid(out_valid), .out_ready(out_ready), .azimuth(azimuth)
  );

  paz_azimuth_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .out_valid(out_valid), .out_ready(out_ready), .azimuth(azimuth),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // offer one pair and hold it until the transfer; returns on a falling edge
  task automatic send_pair(input coord_t fx, input coord_t fy,
                           input coord_t sx, input coord_t sy);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    first_x  <= fx;
    first_y  <= fy;
    second_x <= sx;
    second_y <= sy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_pair();
    int     sel;
    int     s;
    coord_t bx, by, d, e;
    sel = $urandom_range(9);
    bx  = $urandom;
    by  = $urandom;
    d   = $urandom;
    e   = $urandom;
    s   = int'($urandom_range(4)) - 2;
    case (sel)
      0, 1, 2, 3: send_pair(d, e, bx, by);
      4, 5: send_pair(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                      int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8);
      6: send_pair(bx, by, bx, by);
      7: begin
        // one difference zero: lands on an axis
        if ($urandom_range(1)) send_pair(bx + d, by, bx, by);
        else send_pair(bx, by + d, bx, by);
      end
      8: begin
        e = $urandom_range(1) ? d : -d;
        send_pair(bx + d, by + e, bx, by);
      end
      default: begin
        if ($urandom_range(1)) send_pair(bx + d, by + s, bx, by);
        else send_pair(bx + s, by + d, bx, by);
      end
    endcase
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    first_x   = '0;
    first_y   = '0;
    second_x  = '0;
    second_y  = '0;
    send_idle = 35;
    recv_idle = 87;
    hold_req  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_pair(0, 0, 0, 0);                   // both differences zero
    send_pair(C_MAX, C_MIN, C_MAX, C_MIN);   // same point at the extremes
    send_pair(C_MIN, C_MIN, C_MIN, C_MIN);
    send_pair(C_MAX, C_MAX, C_MAX, C_MAX);
    send_pair(7, 3, 2, 3);
    send_pair(-4, 9, 6, 9);                  // dy zero, dx negative
    send_pair(3, 8, 3, -1);
    send_pair(3, -8, 3, 1);
    send_pair(5, 5, 0, 0);
    send_pair(-5, 5, 0, 0);
    send_pair(-5, -5, 0, 0);
    send_pair(5, -5, 0, 0);
    send_pair(C_MAX, 0, C_MIN, 0);
    send_pair(C_MIN, 0, C_MAX, 0);
    send_pair(0, C_MAX, 0, C_MIN);
    send_pair(0, C_MIN, 0, C_MAX);
    send_pair(C_MAX, C_MAX, C_MIN, C_MIN);
    send_pair(C_MIN, C_MAX, C_MAX, C_MIN);
    send_pair(C_MAX, -1, C_MIN, 0);          // rounds up to a full circle, wraps
    send_pair(C_MIN, 1, C_MAX, 0);
    send_pair(C_MIN, -1, C_MAX, 0);
    send_pair(1, C_MAX, 0, C_MIN);

    repeat (PHASE_PAIRS) random_pair();
    send_idle = 87;
    recv_idle = 35;
    repeat (PHASE_PAIRS) random_pair();
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;                        // long stall while input keeps coming
    repeat (PHASE_PAIRS) random_pair();
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
